@@ hdl/strided_slice_color_decompose_assert.svh @@
// assertion macros for the strided slice color decomposer
// used by the port checker; no other dependencies
`ifndef STRIDED_SLICE_COLOR_DECOMPOSE_ASSERT_SVH
`define STRIDED_SLICE_COLOR_DECOMPOSE_ASSERT_SVH

// same-cycle implication, off while reset is high
`define SSCD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, with an explicit disable term
`define SSCD_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/sscd_pkg.sv @@
// shared constants and types for the strided slice color decomposer
// no dependencies
`default_nettype none
package sscd_pkg;
   localparam int NUM_DIMS  = 4;
   localparam int MAX_DIMS  = 4;
   localparam int COLOR_W   = 32;
   localparam int COORD_W   = 16;
   localparam int CNT_W     = 17;
   localparam int SLICE_W   = 48;
   localparam int CELLS     = 32;
   localparam int DIV_STEPS = 17;
   localparam int IDX_W     = 3;
   localparam int DIM_W     = 3;

   localparam logic [IDX_W-1:0] REG_NUM_DIMS = 3'd0;
   localparam logic [IDX_W-1:0] REG_DIM0     = 3'd1;
   localparam logic [IDX_W-1:0] REG_DIM3     = 3'd4;

   typedef struct packed {
      logic [COLOR_W-1:0]               dividend;
      logic [NUM_DIMS-1:0][COLOR_W-1:0] drem;
      logic [NUM_DIMS-1:0][CNT_W-1:0]   mrem;
   } lane_type;

   typedef struct packed {
      logic [NUM_DIMS-1:0][COLOR_W-1:0] prod;
      logic [NUM_DIMS-1:0][CNT_W-1:0]   count;
   } radix_type;
endpackage
`default_nettype wire

@@ hdl/strided_slice_color_decompose.sv @@
// top level of the strided slice color decomposer
// depends on sscd_pkg, sscd_setup, sscd_cell, sscd_coord
//
//   channel  dir  carries
//   req_     in   color index, tdata[31:0]
//   rsp_     out  coord_0..coord_3 in tdata, bad_setup in tuser
//   csr_     in   register writes, index in csr_addr
//
// one color per cycle sustained unless rsp_ stalls or a setup pass runs; a result passes
// through 32 divider cells, one multiply stage and one output stage
// after reset and after every register write a setup pass derives
// the counts and radix products (17-step divider and a multiply per dimension);
// req_tready stays low during it
// a stalled rsp_ fills the cell chain up before req_tready drops
`default_nettype none
module strided_slice_color_decompose (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [31:0]                   req_tdata,  // color
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [63:0]                        rsp_tdata,  // coord_0, coord_1, coord_2, coord_3
   output logic                               rsp_tuser,  // bad_setup
   input  wire logic                          csr_we,
   input  wire logic [sscd_pkg::IDX_W-1:0]    csr_addr,
   input  wire logic [sscd_pkg::SLICE_W-1:0]  csr_wdata
);
   logic [sscd_pkg::NUM_DIMS-1:0][sscd_pkg::SLICE_W-1:0] slice;
   sscd_pkg::radix_type radix;
   logic [sscd_pkg::NUM_DIMS-1:0] dim_used;
   logic bad, busy;

   sscd_pkg::lane_type lane [0:sscd_pkg::CELLS];
   logic vld [0:sscd_pkg::CELLS];
   logic rdy [0:sscd_pkg::CELLS];

   sscd_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .slice     (slice),
      .radix     (radix),
      .dim_used  (dim_used),
      .bad       (bad),
      .busy      (busy)
   );

   // chain entry: remainders start at zero
   always_comb begin
      lane[0].dividend = req_tdata;
      lane[0].drem     = '0;
      lane[0].mrem     = '0;
   end
   assign vld[0]     = req_tvalid & ~busy;
   assign req_tready = rdy[0] & ~busy;

   // cell k settles quotient bit 31-k of every dimension
   for (genvar k = 0; k < sscd_pkg::CELLS; k++) begin : g_cell
      sscd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .radix     (radix),
         .in_valid  (vld[k]),
         .in_ready  (rdy[k]),
         .in_data   (lane[k]),
         .out_valid (vld[k+1]),
         .out_ready (rdy[k+1]),
         .out_data  (lane[k+1])
      );
   end

   // digits are the mod-count remainders after the last cell
   sscd_coord u_coord (
      .clock      (clock),
      .reset      (reset),
      .slice      (slice),
      .dim_used   (dim_used),
      .bad        (bad),
      .in_valid   (vld[sscd_pkg::CELLS]),
      .in_ready   (rdy[sscd_pkg::CELLS]),
      .in_data    (lane[sscd_pkg::CELLS]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_coords (rsp_tdata),
      .out_bad    (rsp_tuser)
   );
endmodule
`default_nettype wire

@@ hdl/sscd_setup.sv @@
// configuration registers and the setup pass that derives counts and radix products
// depends on sscd_pkg
`default_nettype none
module sscd_setup (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        csr_we,
   input  wire logic [sscd_pkg::IDX_W-1:0]                  csr_addr,
   input  wire logic [sscd_pkg::SLICE_W-1:0]                csr_wdata,
   output logic [sscd_pkg::NUM_DIMS-1:0][sscd_pkg::SLICE_W-1:0] slice,
   output sscd_pkg::radix_type                              radix,
   output logic [sscd_pkg::NUM_DIMS-1:0]                    dim_used,
   output logic                                             bad,
   output logic                                             busy
);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_MUL  = 2'd3;

   logic [sscd_pkg::DIM_W-1:0] ndims_ff, ndims_in;
   logic [sscd_pkg::NUM_DIMS-1:0][sscd_pkg::SLICE_W-1:0] slice_ff, slice_in;
   logic [1:0] state_ff, state_in;
   logic [1:0] dim_ff, dim_in;
   logic [4:0] step_ff, step_in;
   logic [sscd_pkg::CNT_W-1:0] num_ff, num_in, rem_ff, rem_in;
   logic [sscd_pkg::NUM_DIMS-1:0][sscd_pkg::COLOR_W-1:0] prod_ff, prod_in;
   logic [sscd_pkg::NUM_DIMS-1:0][sscd_pkg::CNT_W-1:0] count_ff, count_in;
   logic [15:0] first_w, last_w, stride_w;
   logic [sscd_pkg::CNT_W:0] span_w;
   logic [sscd_pkg::CNT_W-1:0] trial_w;
   logic [sscd_pkg::COLOR_W+sscd_pkg::CNT_W-1:0] mul_w;
   logic [sscd_pkg::DIM_W-1:0] neff_w;
   logic [sscd_pkg::NUM_DIMS-1:0] ok_w;

   always_comb begin
      first_w  = slice_ff[dim_ff][15:0];
      last_w   = slice_ff[dim_ff][31:16];
      stride_w = slice_ff[dim_ff][47:32];
      span_w   = {2'b00, last_w} - {2'b00, first_w} + {2'b00, stride_w};
      trial_w  = {rem_ff[sscd_pkg::CNT_W-2:0], num_ff[sscd_pkg::CNT_W-1]};
      mul_w    = prod_ff[dim_ff] * num_ff;
   end

   always_comb begin
      ndims_in = ndims_ff;
      slice_in = slice_ff;
      state_in = state_ff;
      dim_in   = dim_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      prod_in  = prod_ff;
      count_in = count_ff;
      prod_in[0] = sscd_pkg::COLOR_W'(1);
      case (state_ff)
         ST_LOAD: begin
            num_in   = span_w[sscd_pkg::CNT_W-1:0];
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // one quotient bit a cycle, quotient shifts into num
            if (trial_w >= {1'b0, stride_w}) begin
               rem_in = trial_w - {1'b0, stride_w};
               num_in = {num_ff[sscd_pkg::CNT_W-2:0], 1'b1};
            end else begin
               rem_in = trial_w;
               num_in = {num_ff[sscd_pkg::CNT_W-2:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(sscd_pkg::DIV_STEPS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            count_in[dim_ff] = num_ff;
            if (dim_ff == 2'(sscd_pkg::NUM_DIMS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               prod_in[dim_ff + 2'd1] = mul_w[sscd_pkg::COLOR_W-1:0];
               dim_in   = dim_ff + 2'd1;
               state_in = ST_LOAD;
            end
         end
         default: begin
         end
      endcase
      if (csr_we) begin
         if (csr_addr == sscd_pkg::REG_NUM_DIMS) begin
            ndims_in = csr_wdata[sscd_pkg::DIM_W-1:0];
         end else if (csr_addr inside {[sscd_pkg::REG_DIM0:sscd_pkg::REG_DIM3]}) begin
            slice_in[2'(csr_addr - sscd_pkg::REG_DIM0)] = csr_wdata;
         end
         dim_in   = '0;
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ndims_ff <= '0;
         for (int d = 0; d < sscd_pkg::NUM_DIMS; d++) begin
            slice_ff[d] <= sscd_pkg::SLICE_W'(48'h0001_0000_0000);
         end
         state_ff <= ST_LOAD;
         dim_ff   <= '0;
      end else begin
         ndims_ff <= ndims_in;
         slice_ff <= slice_in;
         state_ff <= state_in;
         dim_ff   <= dim_in;
      end
      step_ff  <= step_in;
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      prod_ff  <= prod_in;
      count_ff <= count_in;
   end

   always_comb begin
      neff_w = (ndims_ff > sscd_pkg::DIM_W'(sscd_pkg::MAX_DIMS))
             ? sscd_pkg::DIM_W'(sscd_pkg::MAX_DIMS) : ndims_ff;
      for (int d = 0; d < sscd_pkg::NUM_DIMS; d++) begin
         dim_used[d] = sscd_pkg::DIM_W'(d) < neff_w;
         ok_w[d] = (slice_ff[d][47:32] != 16'd0) && (slice_ff[d][31:16] >= slice_ff[d][15:0])
                 && (prod_ff[d] != '0);
      end
      bad = |(dim_used & ~ok_w);
   end

   assign slice       = slice_ff;
   assign radix.prod  = prod_ff;
   assign radix.count = count_ff;
   assign busy        = state_ff != ST_IDLE;
endmodule
`default_nettype wire

@@ hdl/sscd_cell.sv @@
// one cell of the divider chain: one quotient bit of color / product and
// the matching running remainder modulo the count, for every dimension
// depends on sscd_pkg
`default_nettype none
module sscd_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sscd_pkg::radix_type radix,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire sscd_pkg::lane_type  in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output sscd_pkg::lane_type       out_data
);
   logic valid_ff, valid_in;
   sscd_pkg::lane_type data_ff, data_in;
   logic [sscd_pkg::COLOR_W:0] trial;
   logic [sscd_pkg::CNT_W:0] mtrial;
   logic qbit;

   always_comb begin
      data_in.dividend = {in_data.dividend[sscd_pkg::COLOR_W-2:0], 1'b0};
      data_in.drem = '0;
      data_in.mrem = '0;
      trial  = '0;
      mtrial = '0;
      qbit   = 1'b0;
      for (int d = 0; d < sscd_pkg::NUM_DIMS; d++) begin
         trial = {in_data.drem[d], in_data.dividend[sscd_pkg::COLOR_W-1]};
         qbit  = trial >= {1'b0, radix.prod[d]};
         if (qbit) begin
            trial = trial - {1'b0, radix.prod[d]};
         end
         data_in.drem[d] = trial[sscd_pkg::COLOR_W-1:0];
         // quotient bits arrive msb first, fold them into the remainder mod count
         mtrial = {in_data.mrem[d], qbit};
         if (mtrial >= {1'b0, radix.count[d]}) begin
            mtrial = mtrial - {1'b0, radix.count[d]};
         end
         data_in.mrem[d] = mtrial[sscd_pkg::CNT_W-1:0];
      end
   end

   assign in_ready = ~valid_ff | out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

@@ hdl/sscd_coord.sv @@
// turns digits into coordinates: multiply by stride, then add first and mask
// depends on sscd_pkg
`default_nettype none
module sscd_coord (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic [sscd_pkg::NUM_DIMS-1:0][sscd_pkg::SLICE_W-1:0] slice,
   input  wire logic [sscd_pkg::NUM_DIMS-1:0]                dim_used,
   input  wire logic                                         bad,
   input  wire logic                                         in_valid,
   output logic                                              in_ready,
   input  wire sscd_pkg::lane_type                           in_data,
   output logic                                              out_valid,
   input  wire logic                                         out_ready,
   output logic [sscd_pkg::NUM_DIMS*sscd_pkg::COORD_W-1:0]   out_coords,
   output logic                                              out_bad
);
   logic v1_ff, v1_in, v2_ff, v2_in, r1, r2;
   logic [sscd_pkg::NUM_DIMS-1:0][sscd_pkg::COORD_W-1:0] mul_ff, mul_in, crd_ff, crd_in;
   logic bad_ff;
   logic [2*sscd_pkg::COORD_W-1:0] full;

   always_comb begin
      mul_in = '0;
      crd_in = '0;
      full   = '0;
      for (int d = 0; d < sscd_pkg::NUM_DIMS; d++) begin
         full = in_data.mrem[d][sscd_pkg::COORD_W-1:0] * slice[d][47:32];
         mul_in[d] = full[sscd_pkg::COORD_W-1:0];
         crd_in[d] = (dim_used[d] && !bad) ? mul_ff[d] + slice[d][15:0] : '0;
      end
   end

   assign r2 = ~v2_ff | out_ready;
   assign r1 = ~v1_ff | r2;
   assign v1_in = r1 ? in_valid : v1_ff;
   assign v2_in = r2 ? v1_ff : v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
      if (in_valid && r1) begin
         mul_ff <= mul_in;
      end
      if (v1_ff && r2) begin
         crd_ff <= crd_in;
         bad_ff <= bad;
      end
   end

   assign in_ready   = r1;
   assign out_valid  = v2_ff;
   assign out_coords = crd_ff;
   assign out_bad    = bad_ff;
endmodule
`default_nettype wire

@@ hdl/sscd_checker.sv @@
// port checker for the strided slice color decomposer, bound to the top level
// depends on strided_slice_color_decompose_assert.svh
`default_nettype none
`include "strided_slice_color_decompose_assert.svh"
module sscd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        csr_we
);
   // a stalled result holds
   `SSCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // a bad setup zeros every coordinate
   `SSCD_ASSERT_IMPLY(a_bad_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == 64'd0)
   // nothing comes out right after reset
   `SSCD_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_tvalid)
   // a register write starts the setup pass, which blocks input
   `SSCD_ASSERT_NEXT(a_setup_block, clock, reset, csr_we, !req_tready)
endmodule

bind strided_slice_color_decompose sscd_checker u_sscd_checker (.*);
`default_nettype wire

@@ tb/tb_strided_slice_color_decompose.sv @@
// testbench for strided_slice_color_decompose: directed table then random phases
// depends on sscd_pkg and the block itself; self-checking with its own decomposer
`timescale 1ns / 100ps
`default_nettype none
module tb_strided_slice_color_decompose;

   typedef struct packed {
      logic [3:0][sscd_pkg::COORD_W-1:0] coord;   // coord[0] in the low bits
      logic                              bad;
   } slice_result_type;

   // directed setups
   localparam int SET_RESET   = 0;  // registers as after reset, nothing in use
   localparam int SET_FULL2   = 1;  // two full 16-bit windows, stride 1
   localparam int SET_WRAP    = 2;  // four full windows, radix product wraps to zero
   localparam int SET_STRIDE0 = 3;  // zero stride on dimension 0
   localparam int SET_INVERT  = 4;  // last below first on dimension 2
   localparam int SET_CLAMP   = 5;  // seven dimensions asked, four used
   localparam int SET_TOP     = 6;  // single window at the very top of the range

   localparam int IDLE_LIMIT  = 5000;
   localparam int DRAIN_WAIT  = 40;   // longer than the path through the cell chain and the coord stages

   typedef struct {
      int               setup;
      logic [31:0]      color;
      bit               typed;    // expectation given here rather than predicted
      slice_result_type result;
   } dir_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [31:0]                     req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [63:0]                     rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_we = 1'b0;
   logic [sscd_pkg::IDX_W-1:0]      csr_addr = '0;
   logic [sscd_pkg::SLICE_W-1:0]    csr_wdata = '0;

   // shadow of the register file
   logic [2:0]                      num_dims_q;
   logic [sscd_pkg::SLICE_W-1:0]    dim_slice_q [sscd_pkg::NUM_DIMS];

   slice_result_type     pending_results[$];
   slice_result_type     typed_results[$];   // typed expectations, one per typed transfer
   bit                   use_typed = 1'b0;
   int                   errors = 0;
   int                   accepted = 0;
   int                   returned = 0;
   int                   bad_seen = 0;
   int                   idle_cycles = 0;
   int                   setups_run = 0;

   strided_slice_color_decompose i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mixed-radix split of a color under the shadow registers
   function automatic slice_result_type decompose(input logic [31:0] color);
      slice_result_type r;
      logic [31:0]      prod, first, last, stride, span, cnt, digit;
      int               n;
      r = '0;
      prod = 32'd1;
      n = (num_dims_q > 3'd4) ? 4 : int'(num_dims_q);
      for (int d = 0; d < n; d++) begin
         first  = {16'd0, dim_slice_q[d][15:0]};
         last   = {16'd0, dim_slice_q[d][31:16]};
         stride = {16'd0, dim_slice_q[d][47:32]};
         if (stride == 0 || last < first || prod == 0) begin
            r.bad = 1'b1;
            break;
         end
         span  = last - first + 32'd1;
         cnt   = (span + stride - 32'd1) / stride;
         digit = (color / prod) % cnt;
         r.coord[d] = 16'(digit * stride + first);
         prod = prod * cnt;   // wraps at 32 bits
      end
      if (r.bad)
         r.coord = '0;
      return r;
   endfunction

   function automatic logic [sscd_pkg::SLICE_W-1:0] slice(input logic [15:0] first, last,
                                                           stride);
      return {stride, last, first};
   endfunction

   // register write, issued only with no colors in flight
   task automatic write_reg(input logic [sscd_pkg::IDX_W-1:0] idx,
                            input logic [sscd_pkg::SLICE_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      if (idx == sscd_pkg::REG_NUM_DIMS)
         num_dims_q = value[2:0];
      else if (idx inside {[sscd_pkg::REG_DIM0:sscd_pkg::REG_DIM3]})
         dim_slice_q[idx - sscd_pkg::REG_DIM0] = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic apply_setup(input int id);
      wait_idle();
      setups_run++;
      case (id)
         SET_FULL2: begin
            write_reg(sscd_pkg::REG_NUM_DIMS, 48'd2);
            write_reg(sscd_pkg::REG_DIM0, slice(16'h0000, 16'hffff, 16'd1));
            write_reg(sscd_pkg::REG_DIM0 + 3'd1, slice(16'h0000, 16'hffff, 16'd1));
         end
         SET_WRAP: begin
            write_reg(sscd_pkg::REG_NUM_DIMS, 48'd4);
            write_reg(sscd_pkg::REG_DIM0 + 3'd2, slice(16'h0000, 16'hffff, 16'd1));
            write_reg(sscd_pkg::REG_DIM3, slice(16'h0000, 16'hffff, 16'd1));
         end
         SET_STRIDE0: begin
            write_reg(sscd_pkg::REG_NUM_DIMS, 48'd1);
            write_reg(sscd_pkg::REG_DIM0, slice(16'h0003, 16'h0010, 16'd0));
         end
         SET_INVERT: begin
            write_reg(sscd_pkg::REG_NUM_DIMS, 48'd3);
            write_reg(sscd_pkg::REG_DIM0, slice(16'd2, 16'd9, 16'd2));
            write_reg(sscd_pkg::REG_DIM0 + 3'd1, slice(16'd0, 16'd4, 16'd1));
            write_reg(sscd_pkg::REG_DIM0 + 3'd2, slice(16'd5, 16'd4, 16'd1));
         end
         SET_CLAMP: begin
            write_reg(sscd_pkg::REG_NUM_DIMS, 48'd7);
            write_reg(sscd_pkg::REG_DIM0, slice(16'd1, 16'd10, 16'd3));
            write_reg(sscd_pkg::REG_DIM0 + 3'd1, slice(16'd100, 16'd106, 16'd2));
            write_reg(sscd_pkg::REG_DIM0 + 3'd2, slice(16'd7, 16'd7, 16'd9));
            write_reg(sscd_pkg::REG_DIM3, slice(16'hfff0, 16'hffff, 16'd5));
            // unknown index, must leave everything alone
            write_reg(3'd6, 48'hffff_ffff_ffff);
         end
         SET_TOP: begin
            write_reg(sscd_pkg::REG_NUM_DIMS, 48'd1);
            write_reg(sscd_pkg::REG_DIM0, slice(16'hffff, 16'hffff, 16'hffff));
         end
         default: ;
      endcase
      // setup pass follows every write; req_tready handles it
   endtask

   task automatic random_setup();
      logic [15:0] first, last, stride;
      wait_idle();
      setups_run++;
      write_reg(sscd_pkg::REG_NUM_DIMS, {45'd0, 3'($urandom_range(0, 7))});
      for (int d = 0; d < sscd_pkg::NUM_DIMS; d++) begin
         case ($urandom_range(0, 9))
            0: stride = 16'd0;
            1: stride = 16'($urandom);
            default: stride = 16'($urandom_range(1, 6));
         endcase
         first = 16'($urandom);
         if ($urandom_range(0, 9) == 0)
            last = 16'($urandom);                 // often below first
         else if ($urandom_range(0, 3) == 0)
            last = 16'hffff;
         else
            last = (first > 16'hffc0) ? 16'hffff : first + 16'($urandom_range(0, 60));
         write_reg(sscd_pkg::REG_DIM0 + 3'(d), slice(first, last, stride));
      end
      if ($urandom_range(0, 3) == 0)
         write_reg(3'($urandom_range(5, 7)), 48'($urandom) << 16);
   endtask

   // one transfer on req_, valid stays up after acceptance
   task automatic send_color(input logic [31:0] color);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= color;
      do @(posedge clock); while (!req_tready);
   endtask

   // bursts of random length with random gaps
   int burst_left = 0;
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic close_sender();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // receiver stall pattern: modes of always ready, coin flip, long stalls
   int stall_mode = 0;
   int mode_left = 0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(10, 80);
      end
      mode_left--;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         default: rsp_tready <= ($urandom_range(0, 19) == 0);
      endcase
   end

   // record a prediction for every accepted color
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         accepted++;
         if (use_typed && typed_results.size() != 0)
            pending_results.push_back(typed_results.pop_front());
         else
            pending_results.push_back(decompose(req_tdata));
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      slice_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.coord = rsp_tdata;
         got.bad   = rsp_tuser;
         returned++;
         if (got.bad)
            bad_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result coords=%h bad=%b", $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = pending_results.pop_front();
            for (int d = 0; d < sscd_pkg::NUM_DIMS; d++)
               if (want.coord[d] !== got.coord[d]) begin
                  $display("%0t: coord_%0d expected %h actual %h", $time, d,
                           want.coord[d], got.coord[d]);
                  errors++;
               end
            if (want.bad !== got.bad) begin
               $display("%0t: bad_setup expected %b actual %b", $time, want.bad, got.bad);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer or write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   dir_row_type dir_rows[$];

   function automatic slice_result_type all_bad();
      slice_result_type r;
      r = '0;
      r.bad = 1'b1;
      return r;
   endfunction

   function automatic slice_result_type one_coord(input logic [15:0] c0);
      slice_result_type r;
      r = '0;
      r.coord[0] = c0;
      return r;
   endfunction

   initial begin
      int cur_setup;
      num_dims_q = '0;
      for (int d = 0; d < sscd_pkg::NUM_DIMS; d++)
         dim_slice_q[d] = 48'h0001_0000_0000;

      // directed table; typed rows carry an expectation read straight off the setup
      dir_rows = '{
         '{SET_RESET,   32'h0000_0000, 1, slice_result_type'(0)},
         '{SET_RESET,   32'hffff_ffff, 1, slice_result_type'(0)},
         '{SET_RESET,   32'h8000_0001, 1, slice_result_type'(0)},
         '{SET_FULL2,   32'h0000_0000, 0, slice_result_type'(0)},
         '{SET_FULL2,   32'hffff_ffff, 0, slice_result_type'(0)},
         '{SET_FULL2,   32'h1234_abcd, 0, slice_result_type'(0)},
         '{SET_FULL2,   32'h5555_aaaa, 0, slice_result_type'(0)},
         '{SET_WRAP,    32'h0000_0000, 1, all_bad()},
         '{SET_WRAP,    32'hffff_ffff, 1, all_bad()},
         '{SET_STRIDE0, 32'h0000_0007, 1, all_bad()},
         '{SET_STRIDE0, 32'hffff_ffff, 1, all_bad()},
         '{SET_INVERT,  32'h0000_0003, 1, all_bad()},
         '{SET_INVERT,  32'haaaa_5555, 1, all_bad()},
         '{SET_CLAMP,   32'h0000_0000, 0, slice_result_type'(0)},
         '{SET_CLAMP,   32'h0000_0001, 0, slice_result_type'(0)},
         '{SET_CLAMP,   32'h0000_00a5, 0, slice_result_type'(0)},
         '{SET_CLAMP,   32'hffff_ffff, 0, slice_result_type'(0)},
         '{SET_CLAMP,   32'h8000_0000, 0, slice_result_type'(0)},
         '{SET_TOP,     32'h0000_0000, 1, one_coord(16'hffff)},
         '{SET_TOP,     32'hffff_ffff, 1, one_coord(16'hffff)},
         '{SET_TOP,     32'h7fff_fffe, 1, one_coord(16'hffff)}
      };

      // reset held from the start, released once
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      cur_setup = SET_RESET;
      use_typed = 1'b1;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].setup != cur_setup) begin
            close_sender();
            cur_setup = dir_rows[i].setup;
            apply_setup(cur_setup);
         end
         // typed rows hand their value to the monitor, others get predicted
         if (dir_rows[i].typed)
            typed_results.push_back(dir_rows[i].result);
         send_color(dir_rows[i].color);
         close_sender();
      end
      use_typed = 1'b0;

      // random phases, each under a freshly drawn register setting
      for (int p = 0; p < 8; p++) begin
         close_sender();
         random_setup();
         for (int k = 0; k < 50; k++) begin
            case ($urandom_range(0, 7))
               0: send_color(32'($urandom_range(0, 255)));
               1: send_color(32'hffff_ffff - 32'($urandom_range(0, 255)));
               default: send_color($urandom);
            endcase
            pace_sender();
         end
      end
      close_sender();

      wait_idle();
      $display("covered %0d setups, %0d colors in, %0d results out, %0d flagged bad",
               setups_run, accepted, returned, bad_seen);
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
